/* rtl/gtg_pkg.sv */
package gtg_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned SQRT_STEPS       = 17;
  localparam int unsigned ATAN_IDX_W       = 5;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned HEAD_W     = 15;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned CX_W       = 28;
  localparam int unsigned Z_W        = 34;
  localparam int unsigned SQ_W       = 34;
  localparam int unsigned ROOT_W     = 35;
  localparam int unsigned BIT_W      = 33;
  localparam int unsigned DIST_W     = 17;
  localparam int unsigned BEAR_W     = 16;
  localparam int unsigned ERR_W      = 18;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned LIN_W      = 16;
  localparam int unsigned ANG_W      = 18;
  localparam int unsigned MUL_W      = 18;
  localparam int unsigned PROD_W     = 36;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W   = 48;
  localparam int unsigned M_DATA_W   = 40;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ITER,
    ST_LIN,
    ST_ANG,
    ST_FIN
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X   = 3'd0,
    REG_GOAL_Y   = 3'd1,
    REG_TOL      = 3'd2,
    REG_LIN_GAIN = 3'd3,
    REG_ANG_GAIN = 3'd4
  } cfg_reg_e;

  // atan(2^-i) in Q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 34'sh03243F6A8;
      5'd1:    r = 34'sh01DAC6705;
      5'd2:    r = 34'sh00FADBAFC;
      5'd3:    r = 34'sh007F56EA6;
      5'd4:    r = 34'sh003FEAB76;
      5'd5:    r = 34'sh001FFD55B;
      5'd6:    r = 34'sh000FFFAAA;
      5'd7:    r = 34'sh0007FFF55;
      5'd8:    r = 34'sh0003FFFEA;
      5'd9:    r = 34'sh0001FFFFD;
      5'd10:   r = 34'sh0000FFFFF;
      5'd11:   r = 34'sh00007FFFF;
      5'd12:   r = 34'sh00003FFFF;
      5'd13:   r = 34'sh00001FFFF;
      5'd14:   r = 34'sh00000FFFF;
      5'd15:   r = 34'sh000007FFF;
      5'd16:   r = 34'sh000003FFF;
      5'd17:   r = 34'sh000001FFF;
      5'd18:   r = 34'sh000000FFF;
      5'd19:   r = 34'sh0000007FF;
      5'd20:   r = 34'sh0000003FF;
      5'd21:   r = 34'sh0000001FF;
      5'd22:   r = 34'sh0000000FF;
      5'd23:   r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/go_to_goal_p_controller.sv */
// Operation: after the input transfer the controller steps through ST_SQX, ST_SQY, ST_SUM,
//   the shared iteration loop ST_ITER, ST_LIN, ST_ANG (skipped once the goal is reached) and
//   ST_FIN, which loads the output register once it is free.
// The next pose is taken while the previous result still waits in the output register.
// Reset: asynchronous, active low; configuration registers return to their default goal and gains.
module go_to_goal_p_controller
  import gtg_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pose_x [15:0], pose_y [31:16], pose_heading [46:32]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // linear_velocity [15:0], angular_velocity [33:16]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // arrived [0]
  output logic                  m_axis_tuser
);

  localparam int unsigned ITER_N = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int unsigned CNT_W  = $clog2(ITER_N + 1);

  state_e state_q, state_d;

  logic signed [POS_W-1:0]  goal_x_q, goal_y_q;
  logic [TOL_W-1:0]         tol_q;
  logic [GAIN_W-1:0]        lin_gain_q, ang_gain_q;
  logic                     goal_reached_q;

  logic signed [HEAD_W-1:0] hd_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0]          n_q;
  logic [ROOT_W-1:0]        root_q;
  logic [BIT_W-1:0]         bit_q;
  logic signed [CX_W-1:0]   cx_q, cy_q;
  logic signed [Z_W-1:0]    z_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [ERR_W-1:0]  err_q;
  logic [LIN_W-1:0]         lin_q;
  logic                     arr_q;

  logic                     out_valid_q;
  logic [LIN_W-1:0]         out_lin_q;
  logic [ANG_W-1:0]         out_ang_q;
  logic                     out_arr_q;

  logic                     in_xfer, out_free, arrive_now;
  logic [DIST_W-1:0]        distance;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mult;
  logic [ROOT_W-1:0]        trial;
  logic signed [CX_W-1:0]   xs, ys, x0, y0;
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [BEAR_W-1:0] bearing;
  logic [30:0]              lin_sum;
  logic [22:0]              lin_full;
  logic signed [PROD_W-1:0] ang_sum;
  logic signed [27:0]       ang_sh;
  logic [ANG_W-1:0]         ang_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign distance      = root_q[DIST_W-1:0];
  assign arrive_now    = goal_reached_q || (distance <= {1'b0, tol_q});

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = {dx_q[DIFF_W-1], dx_q};
        mul_b = {dx_q[DIFF_W-1], dx_q};
      end
      ST_SQY: begin
        mul_a = {dy_q[DIFF_W-1], dy_q};
        mul_b = {dy_q[DIFF_W-1], dy_q};
      end
      ST_LIN: begin
        mul_a = {6'b0, lin_gain_q};
        mul_b = {1'b0, distance};
      end
      ST_ANG: begin
        mul_a = {6'b0, ang_gain_q};
        mul_b = err_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mult = mul_a * mul_b;

  assign trial = root_q + {2'b0, bit_q};
  assign xs    = cx_q >>> cnt_q;
  assign ys    = cy_q >>> cnt_q;
  assign x0    = {{3{dx_q[DIFF_W-1]}}, dx_q, 8'b0};
  assign y0    = {{3{dy_q[DIFF_W-1]}}, dy_q, 8'b0};

  assign z_rnd    = z_q + 34'sd131072;
  assign bearing  = z_rnd[Z_W-1:18];

  assign lin_sum  = {1'b0, prod_q[29:0]} + 31'd128;
  assign lin_full = lin_sum[30:8];

  assign ang_sum  = prod_q + 36'sd128;
  assign ang_sh   = ang_sum[PROD_W-1:8];
  always_comb begin
    if (ang_sh > 28'sd131071) begin
      ang_sat = 18'h1FFFF;
    end else if (ang_sh < -28'sd131072) begin
      ang_sat = 18'h20000;
    end else begin
      ang_sat = ang_sh[ANG_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ITER;
      ST_ITER: if (cnt_q == CNT_W'(ITER_N - 1)) state_d = ST_LIN;
      ST_LIN:  state_d = arrive_now ? ST_FIN : ST_ANG;
      ST_ANG:  state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q       <= 16'sd1280;
      goal_y_q       <= 16'sd2304;
      tol_q          <= 16'd26;
      lin_gain_q     <= 12'd128;
      ang_gain_q     <= 12'd1024;
      goal_reached_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GOAL_X: begin
            goal_x_q       <= cfg_data_i;
            goal_reached_q <= 1'b0;
          end
          REG_GOAL_Y: begin
            goal_y_q       <= cfg_data_i;
            goal_reached_q <= 1'b0;
          end
          REG_TOL:      tol_q      <= cfg_data_i;
          REG_LIN_GAIN: lin_gain_q <= cfg_data_i[GAIN_W-1:0];
          REG_ANG_GAIN: ang_gain_q <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end else if (state_q == ST_LIN && arrive_now) begin
        goal_reached_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dx_q <= {goal_x_q[POS_W-1], goal_x_q} - {s_axis_tdata[15], s_axis_tdata[15:0]};
          dy_q <= {goal_y_q[POS_W-1], goal_y_q} - {s_axis_tdata[31], s_axis_tdata[31:16]};
          hd_q <= s_axis_tdata[46:32];
        end
      end
      ST_SQX: prod_q <= mult;
      ST_SQY: begin
        n_q    <= prod_q[SQ_W-1:0];
        prod_q <= mult;
      end
      ST_SUM: begin
        n_q    <= n_q + prod_q[SQ_W-1:0];
        root_q <= '0;
        bit_q  <= {1'b1, 32'b0};
        cnt_q  <= '0;
        // pre-rotate into the right half plane
        if (dx_q[DIFF_W-1]) begin
          if (!dy_q[DIFF_W-1]) begin
            cx_q <= y0;
            cy_q <= -x0;
            z_q  <= HALF_PI_Q30;
          end else begin
            cx_q <= -y0;
            cy_q <= x0;
            z_q  <= -HALF_PI_Q30;
          end
        end else begin
          cx_q <= x0;
          cy_q <= y0;
          z_q  <= '0;
        end
      end
      ST_ITER: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q < CNT_W'(SQRT_STEPS)) begin
          if ({1'b0, n_q} >= trial) begin
            n_q    <= n_q - trial[SQ_W-1:0];
            root_q <= (root_q >> 1) + {2'b0, bit_q};
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        if (cnt_q < CNT_W'(CORDIC_STEPS)) begin
          if (!cy_q[CX_W-1]) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            z_q  <= z_q + atan_q30(ATAN_IDX_W'(cnt_q));
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            z_q  <= z_q - atan_q30(ATAN_IDX_W'(cnt_q));
          end
        end
      end
      ST_LIN: begin
        arr_q  <= arrive_now;
        prod_q <= mult;
        err_q  <= {{2{bearing[BEAR_W-1]}}, bearing} - {{3{hd_q[HEAD_W-1]}}, hd_q};
      end
      ST_ANG: begin
        prod_q <= mult;
        lin_q  <= (|lin_full[22:16]) ? {LIN_W{1'b1}} : lin_full[LIN_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_arr_q <= arr_q;
      out_lin_q <= arr_q ? '0 : lin_q;
      out_ang_q <= arr_q ? '0 : ang_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ang_q, out_lin_q};
  assign m_axis_tuser  = out_arr_q;

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("arrived result carries nonzero velocity");

  a_reached_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (goal_reached_q && !(cfg_we_i && (cfg_idx_i == REG_GOAL_X || cfg_idx_i == REG_GOAL_Y)))
    |=> goal_reached_q)
    else $error("goal reached flag dropped without a goal write");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (cnt_q < CNT_W'(ITER_N)))
    else $error("iteration counter overran");

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  localparam int unsigned SETTLE_CYCLES = CORDIC_STEPS_DEF + 16;
  localparam int unsigned ROT_STEPS     = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
  localparam int unsigned REG_COUNT     = 5;
  localparam int          HEAD_LIMIT    = 12868;
  localparam longint      HALF_PI_Q30_L = 64'sd1686629713;
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]  POS_MAX  = ~POS_MIN;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};
  localparam logic signed [HEAD_W-1:0] HEAD_MAX = ~HEAD_MIN;

  typedef struct packed {
    logic [LIN_W-1:0]        lin;
    logic signed [ANG_W-1:0] ang;
    logic                    arrived;
  } command_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pose_x [15:0], pose_y [31:16], pose_heading [46:32]
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // linear_velocity [15:0], angular_velocity [33:16]
  logic [M_DATA_W-1:0]   m_axis_tdata;
  // arrived [0]
  logic                  m_axis_tuser;

  // controller shadow: setpoint registers and the sticky goal flag
  logic signed [POS_W-1:0] tgt_x    = 16'sd1280;
  logic signed [POS_W-1:0] tgt_y    = 16'sd2304;
  logic [TOL_W-1:0]        tol      = 16'd26;
  logic [GAIN_W-1:0]       lin_gain = 12'd128;
  logic [GAIN_W-1:0]       ang_gain = 12'd1024;
  logic                    at_goal  = 1'b0;

  longint atan_tab [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  int unsigned idle_send_tab  [4] = '{0, 76, 0, 23};
  int unsigned idle_recv_tab  [4] = '{0, 0, 76, 23};

  command_t    pending_cmds [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_arrived = 0;
  int unsigned n_writes  = 0;
  int unsigned n_errors  = 0;

  go_to_goal_p_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint int_sqrt(longint n);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  // atan2(dy, dx) in Q.12 by vectoring; arithmetic shift is floor division
  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    int     i;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    // fold the left half plane into the right one
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y;  y = -t; z = HALF_PI_Q30_L;
      end else begin
        t = x; x = -y; y = t;  z = -HALF_PI_Q30_L;
      end
    end
    for (i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end
    end
    return (z + 131072) >>> 18;
  endfunction

  function automatic command_t predict_command(logic signed [POS_W-1:0] px,
                                               logic signed [POS_W-1:0] py,
                                               logic signed [HEAD_W-1:0] hd);
    command_t c;
    longint   dx, dy, distance, lin, err, ang;
    c        = '0;
    dx       = longint'(tgt_x) - longint'(px);
    dy       = longint'(tgt_y) - longint'(py);
    distance = int_sqrt(dx * dx + dy * dy);
    if (at_goal || distance <= longint'(tol)) begin
      at_goal   = 1'b1;
      c.arrived = 1'b1;
      return c;
    end
    lin = (longint'(lin_gain) * distance + 128) >>> 8;
    if (lin > 65535) lin = 65535;
    err = bearing_q12(dx, dy) - longint'(hd);
    ang = (longint'(ang_gain) * err + 128) >>> 8;
    if (ang > 131071)  ang = 131071;
    if (ang < -131072) ang = -131072;
    c.lin = lin[LIN_W-1:0];
    c.ang = ang[ANG_W-1:0];
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_GOAL_X: begin
        tgt_x   = data;
        at_goal = 1'b0;
      end
      REG_GOAL_Y: begin
        tgt_y   = data;
        at_goal = 1'b0;
      end
      REG_TOL:      tol      = data;
      REG_LIN_GAIN: lin_gain = data[GAIN_W-1:0];
      REG_ANG_GAIN: ang_gain = data[GAIN_W-1:0];
      default: ;
    endcase
    n_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pose(input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py,
                           input logic signed [HEAD_W-1:0] hd);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(S_DATA_W-2*POS_W-HEAD_W){1'b0}}, hd, py, px};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_cmds.push_back(predict_command(px, py, hd));
    n_sent++;
  endtask

  // drop valid, drain every pending command, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned phase);
    send_idle_pct  = idle_send_tab[phase];
    recv_stall_pct = idle_recv_tab[phase];
  endtask

  initial begin : check_commands
    command_t exp_c;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_cmds.size() == 0) begin
          $error("command transfer with no pose pending");
          n_errors++;
        end else begin
          exp_c = pending_cmds.pop_front();
          n_checked++;
          if (exp_c.arrived) n_arrived++;
          if (m_axis_tdata[LIN_W-1:0] !== exp_c.lin) begin
            $error("linear_velocity: expected %0d, got %0d", exp_c.lin,
                   m_axis_tdata[LIN_W-1:0]);
            n_errors++;
          end
          if (m_axis_tdata[LIN_W +: ANG_W] !== exp_c.ang) begin
            $error("angular_velocity: expected %0d, got %0d", exp_c.ang,
                   $signed(m_axis_tdata[LIN_W +: ANG_W]));
            n_errors++;
          end
          if (m_axis_tuser !== exp_c.arrived) begin
            $error("arrived: expected %0d, got %0d", exp_c.arrived, m_axis_tuser);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // default setpoint: all four quadrants, both pre-rotations, axis cases, tolerance edge
  task automatic test_directed_geometry();
    set_idling(0);
    send_pose(POS_MIN, POS_MIN, HEAD_W'(-HEAD_LIMIT));
    send_pose(POS_MAX, POS_MAX, HEAD_W'(HEAD_LIMIT));
    send_pose(POS_MAX, POS_MIN, '0);
    send_pose(POS_MIN, POS_MAX, '0);
    send_pose(POS_MAX, tgt_y, HEAD_MAX);
    send_pose(POS_MIN, tgt_y, HEAD_MIN);
    send_pose(tgt_x, POS_MIN, '0);
    send_pose(tgt_x, POS_MAX, '0);
    send_pose(tgt_x + 16'sd27, tgt_y, '0);
    send_pose(tgt_x + 16'sd26, tgt_y, '0);
    wait_idle();
  endtask

  task automatic test_sticky_arrival();
    send_pose(POS_MIN, POS_MAX, '0);
    wait_idle();
    // tolerance and gains leave the flag set
    write_reg(REG_TOL, 16'd0);
    send_pose(POS_MAX, POS_MIN, 15'sd100);
    wait_idle();
    write_reg(REG_LIN_GAIN, 16'h0200);
    write_reg(REG_ANG_GAIN, 16'h0300);
    send_pose(POS_MIN, POS_MIN, -15'sd100);
    wait_idle();
    write_reg(REG_GOAL_X, tgt_x);
    send_pose(POS_MIN, POS_MAX, 15'sd2000);
    send_pose(tgt_x, tgt_y, '0);
    wait_idle();
    write_reg(REG_GOAL_Y, 16'h0400);
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
              CFG_DATA_W'($urandom));
    send_pose(POS_MAX, POS_MAX, -15'sd2000);
    send_pose(tgt_x + 16'sd1, tgt_y, '0);
    wait_idle();
  endtask

  task automatic test_gain_extremes();
    write_reg(REG_GOAL_X, POS_MAX);
    write_reg(REG_GOAL_Y, POS_MIN);
    write_reg(REG_TOL, 16'd0);
    write_reg(REG_LIN_GAIN, 16'hFFFF);
    write_reg(REG_ANG_GAIN, 16'h0FFF);
    send_pose(POS_MIN, POS_MAX, HEAD_MIN);
    wait_idle();
    write_reg(REG_GOAL_X, POS_MIN);
    write_reg(REG_GOAL_Y, POS_MIN);
    send_pose(POS_MAX, POS_MAX, HEAD_MAX);
    wait_idle();
    // upper data bits must not reach a gain
    write_reg(REG_LIN_GAIN, 16'hF000);
    write_reg(REG_ANG_GAIN, 16'hF000);
    send_pose(POS_MAX, POS_MIN + 16'sd1, HEAD_MAX);
    wait_idle();
    write_reg(REG_TOL, 16'hFFFF);
    write_reg(REG_GOAL_X, 16'd0);
    write_reg(REG_GOAL_Y, 16'd0);
    send_pose(POS_MIN, POS_MIN, '0);
    send_pose(POS_MAX, POS_MAX, '0);
    wait_idle();
  endtask

  task automatic program_setpoint(input bit corner);
    logic [CFG_DATA_W-1:0] gx, gy, tl, lg, ag;
    if (corner) begin
      gx = $urandom_range(1) ? POS_MIN : POS_MAX;
      gy = $urandom_range(1) ? POS_MIN : POS_MAX;
      tl = $urandom_range(1) ? '0 : '1;
      lg = $urandom_range(1) ? '0 : '1;
      ag = $urandom_range(1) ? '0 : '1;
    end else begin
      gx = CFG_DATA_W'($urandom);
      gy = CFG_DATA_W'($urandom);
      tl = CFG_DATA_W'($urandom_range(0, 1023));
      lg = {4'($urandom), ($urandom_range(1) ? 12'($urandom_range(0, 255)) : 12'($urandom))};
      ag = {4'($urandom), ($urandom_range(1) ? 12'($urandom_range(0, 1023)) : 12'($urandom))};
    end
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_TOL, tl);
    write_reg(REG_LIN_GAIN, lg);
    write_reg(REG_ANG_GAIN, ag);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom));
  endtask

  task automatic test_random_traffic();
    logic signed [POS_W-1:0]  px, py;
    logic signed [HEAD_W-1:0] hd;
    int unsigned              sel;
    for (int phase = 0; phase < 4; phase++) begin
      set_idling(phase);
      for (int chunk = 0; chunk < 6; chunk++) begin
        wait_idle();
        program_setpoint(chunk == 5);
        for (int n = 0; n < 25; n++) begin
          // re-arm the goal midway so a sticky arrival does not hide the rest
          if (n == 12) begin
            wait_idle();
            write_reg(REG_GOAL_Y, $urandom_range(1) ? tgt_y : 16'($urandom));
          end
          sel = $urandom_range(99);
          if (sel < 8) begin
            px = POS_W'(tgt_x + (int'($urandom_range(0, 80)) - 40));
            py = POS_W'(tgt_y + (int'($urandom_range(0, 80)) - 40));
          end else if (sel < 30) begin
            px = POS_W'(tgt_x + (int'($urandom_range(0, 4096)) - 2048));
            py = POS_W'(tgt_y + (int'($urandom_range(0, 4096)) - 2048));
          end else begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
          end
          if ($urandom_range(99) < 85)
            hd = HEAD_W'(int'($urandom_range(0, 2 * HEAD_LIMIT)) - HEAD_LIMIT);
          else
            hd = HEAD_W'($urandom);
          send_pose(px, py, hd);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_geometry();
    test_sticky_arrival();
    test_gain_extremes();
    test_random_traffic();
    wait_idle();
    $display("Covered %0d pose transfers and %0d command transfers, %0d of them at goal.",
             n_sent, n_checked, n_arrived);
    $display("Applied %0d register writes over four handshake pressure profiles.", n_writes);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
